@@ design/accel_jerk_threshold_detector_assert.svh @@
// Assertion macros for the accelerometer jerk threshold detector.
`ifndef ACCEL_JERK_THRESHOLD_DETECTOR_ASSERT_SVH
`define ACCEL_JERK_THRESHOLD_DETECTOR_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define AJTD_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define AJTD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/ajtd_pkg.sv @@
// Package with the types and constants of the accelerometer jerk threshold detector.
package ajtd_pkg;

    localparam int AXIS_W        = 16;
    localparam int MAG_W         = 16;
    localparam int JERK_W        = 25;
    localparam int PERIOD_W      = 16;
    localparam int JERK_FRAC_W   = 16;
    localparam int AXIS_BITS_DEF = 16;
    localparam int TICK_BITS_DEF = 32;

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = APB_ADDR_W - 2;

    localparam logic [REG_IDX_W-1:0] REG_ENABLE         = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_SAMPLE_PERIOD  = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_JERK_THRESHOLD = 2'd2;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd10;

    typedef struct packed {
        logic signed [AXIS_W-1:0] accel_x;
        logic signed [AXIS_W-1:0] accel_y;
        logic signed [AXIS_W-1:0] accel_z;
        logic                     read_ok;
    } ajtd_in_t;

    typedef struct packed {
        logic              sampled;
        logic              sample_failed;
        logic [MAG_W-1:0]  magnitude;
        logic [JERK_W-1:0] jerk;
        logic              over_threshold;
    } ajtd_out_t;

    typedef struct packed {
        logic busy;
        logic done;
    } ajtd_sqrt_stat_t;

endpackage

@@ design/accel_jerk_threshold_detector.sv @@
// Top level of the accelerometer jerk threshold detector.
//
// One item is one tick with three axis readings and a read flag; each item gives
// one result. While enabled, the tick counter advances per item, and a sample is
// taken once sample_period ticks have passed since the last one. A tick with no
// sample due, a failed read or a disabled block goes straight to the output
// state. A successful sample runs the axis and difference squares through one
// multiplier, then the magnitude root and, when history exists and the elapsed
// tick count is nonzero, the jerk root through one shared two-bits-per-cycle
// square root unit, then a one-bit-per-cycle divider by the elapsed ticks.
// tick_stall is high until the result is written into the output register.
// A finished result waits in an output register while the next item is taken.
module accel_jerk_threshold_detector
    import ajtd_pkg::*;
#(
    parameter int AXIS_BITS = AXIS_BITS_DEF,
    parameter int TICK_BITS = TICK_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  tick_valid,
    output logic                  tick_stall,
    input  ajtd_in_t              tick_data,
    output logic                  result_valid,
    input  logic                  result_stall,
    output ajtd_out_t             result_data,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

`include "accel_jerk_threshold_detector_assert.svh"

    localparam int DIFF_W = AXIS_BITS + 1;
    localparam int SQ_W   = 2 * DIFF_W;
    localparam int RAD_W  = SQ_W + JERK_FRAC_W;
    localparam int ROOT_W = RAD_W / 2;
    localparam int DCNT_W = $clog2(ROOT_W + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_MAG_ROOT,
        ST_JERK_ROOT,
        ST_DIVIDE,
        ST_OUTPUT
    } state_t;

    state_t state_reg;

    logic                  enable_reg;
    logic [PERIOD_W-1:0]   period_reg;
    logic [JERK_W-1:0]     threshold_reg;

    logic [TICK_BITS-1:0]  tick_count_reg;
    logic [TICK_BITS-1:0]  last_tick_reg;
    logic signed [AXIS_BITS-1:0] prev_axes_reg [3];
    logic [MAG_W-1:0]      magnitude_reg;
    logic [JERK_W-1:0]     jerk_reg;
    logic                  history_reg;

    logic signed [AXIS_BITS-1:0] axis_reg [3];
    logic [TICK_BITS-1:0]  elapsed_reg;
    logic                  jerk_calc_reg;
    logic                  item_en_reg;
    logic                  sampled_reg;
    logic                  failed_reg;
    logic [2:0]            sq_cnt_reg;
    logic [SQ_W-1:0]       prod_reg;
    logic [SQ_W-1:0]       s_acc_reg;
    logic [SQ_W-1:0]       d_acc_reg;
    logic                  sqrt_start_reg;
    logic [TICK_BITS:0]    div_rem_reg;
    logic [ROOT_W-1:0]     div_q_reg;
    logic [DCNT_W-1:0]     div_cnt_reg;

    logic                  result_valid_reg;
    ajtd_out_t             result_reg;

    logic                  tick_accept;
    logic                  cfg_write;
    logic [REG_IDX_W-1:0]  cfg_idx;
    logic [TICK_BITS-1:0]  elapsed;
    logic                  due;
    logic [1:0]            sq_idx;
    logic signed [DIFF_W-1:0] sq_diff;
    logic [DIFF_W-1:0]     sq_mag;
    logic [SQ_W-1:0]       sq_prod;
    logic [RAD_W-1:0]      sqrt_rad;
    logic [ROOT_W-1:0]     sqrt_root;
    ajtd_sqrt_stat_t       sqrt_stat;
    logic [TICK_BITS:0]    div_shift;
    logic                  div_fits;
    logic [TICK_BITS:0]    div_rem_next;
    logic [ROOT_W-1:0]     div_q_next;
    logic                  out_free;

    assign tick_stall  = (state_reg != ST_IDLE);
    assign tick_accept = tick_valid && !tick_stall;
    assign cfg_write   = psel && penable && pwrite;
    assign cfg_idx     = paddr[APB_ADDR_W-1:2];
    assign pready      = 1'b1;

    assign elapsed = tick_count_reg - last_tick_reg;
    assign due     = (elapsed >= TICK_BITS'(period_reg));

    assign sq_idx = (sq_cnt_reg < 3'd3) ? sq_cnt_reg[1:0] : 2'(sq_cnt_reg - 3'd3);

    always_comb
    begin
        if (sq_cnt_reg < 3'd3)
        begin
            sq_diff = DIFF_W'(axis_reg[sq_idx]);
        end
        else
        begin
            sq_diff = DIFF_W'(axis_reg[sq_idx]) - DIFF_W'(prev_axes_reg[sq_idx]);
        end
        sq_mag = sq_diff[DIFF_W-1] ? DIFF_W'(-sq_diff) : DIFF_W'(sq_diff);
    end

    assign sq_prod = SQ_W'(sq_mag) * SQ_W'(sq_mag);

    assign sqrt_rad = (state_reg == ST_JERK_ROOT) ? {d_acc_reg, JERK_FRAC_W'(0)}
                                                  : RAD_W'(s_acc_reg);

    ajtd_isqrt #(
        .RAD_W (RAD_W)
    ) u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start_reg),
        .radicand (sqrt_rad),
        .root     (sqrt_root),
        .status   (sqrt_stat)
    );

    assign div_shift    = {div_rem_reg[TICK_BITS-1:0], div_q_reg[ROOT_W-1]};
    assign div_fits     = (div_shift >= {1'b0, elapsed_reg});
    assign div_rem_next = div_fits ? (div_shift - {1'b0, elapsed_reg}) : div_shift;
    assign div_q_next   = {div_q_reg[ROOT_W-2:0], div_fits};

    assign out_free = !result_valid_reg || !result_stall;

    always_comb
    begin
        prdata = '0;
        unique case (cfg_idx)
            REG_ENABLE:         prdata = APB_DATA_W'(enable_reg);
            REG_SAMPLE_PERIOD:  prdata = APB_DATA_W'(period_reg);
            REG_JERK_THRESHOLD: prdata = APB_DATA_W'(threshold_reg);
            default:            prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            enable_reg       <= 1'b0;
            period_reg       <= PERIOD_RESET;
            threshold_reg    <= '0;
            tick_count_reg   <= '0;
            last_tick_reg    <= '0;
            prev_axes_reg    <= '{default: '0};
            magnitude_reg    <= '0;
            jerk_reg         <= '0;
            history_reg      <= 1'b0;
            sqrt_start_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
            item_en_reg      <= 1'b0;
            sampled_reg      <= 1'b0;
            failed_reg       <= 1'b0;
            jerk_calc_reg    <= 1'b0;
            sq_cnt_reg       <= '0;
            div_cnt_reg      <= '0;
        end
        else
        begin
            sqrt_start_reg <= 1'b0;
            if (result_valid_reg && !result_stall)
            begin
                result_valid_reg <= 1'b0;
            end

            if (cfg_write)
            begin
                unique case (cfg_idx)
                    REG_ENABLE:
                    begin
                        enable_reg    <= pwdata[0];
                        last_tick_reg <= '0;
                        jerk_reg      <= '0;
                        prev_axes_reg <= '{default: '0};
                        history_reg   <= 1'b0;
                        if (!pwdata[0])
                        begin
                            magnitude_reg <= '0;
                        end
                    end
                    REG_SAMPLE_PERIOD:  period_reg    <= pwdata[PERIOD_W-1:0];
                    REG_JERK_THRESHOLD: threshold_reg <= pwdata[JERK_W-1:0];
                    default:            ;
                endcase
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (tick_accept)
                    begin
                        item_en_reg <= enable_reg;
                        sampled_reg <= 1'b0;
                        failed_reg  <= 1'b0;
                        state_reg   <= ST_OUTPUT;
                        if (enable_reg)
                        begin
                            tick_count_reg <= tick_count_reg + 1'b1;
                            if (due)
                            begin
                                last_tick_reg <= tick_count_reg;
                                history_reg   <= 1'b1;
                                if (tick_data.read_ok)
                                begin
                                    axis_reg[0]   <= tick_data.accel_x[AXIS_BITS-1:0];
                                    axis_reg[1]   <= tick_data.accel_y[AXIS_BITS-1:0];
                                    axis_reg[2]   <= tick_data.accel_z[AXIS_BITS-1:0];
                                    elapsed_reg   <= elapsed;
                                    jerk_calc_reg <= history_reg && (elapsed != '0);
                                    s_acc_reg     <= '0;
                                    d_acc_reg     <= '0;
                                    sq_cnt_reg    <= '0;
                                    sampled_reg   <= 1'b1;
                                    state_reg     <= ST_SQUARE;
                                end
                                else
                                begin
                                    failed_reg <= 1'b1;
                                end
                            end
                        end
                    end
                end
                ST_SQUARE:
                begin
                    if (sq_cnt_reg < 3'd6)
                    begin
                        prod_reg <= sq_prod;
                    end
                    if (sq_cnt_reg != 3'd0)
                    begin
                        if (sq_cnt_reg <= 3'd3)
                        begin
                            s_acc_reg <= s_acc_reg + prod_reg;
                        end
                        else
                        begin
                            d_acc_reg <= d_acc_reg + prod_reg;
                        end
                    end
                    sq_cnt_reg <= sq_cnt_reg + 1'b1;
                    if (sq_cnt_reg == 3'd6)
                    begin
                        prev_axes_reg  <= axis_reg;
                        sqrt_start_reg <= 1'b1;
                        state_reg      <= ST_MAG_ROOT;
                    end
                end
                ST_MAG_ROOT:
                begin
                    if (sqrt_stat.done)
                    begin
                        magnitude_reg <= MAG_W'(sqrt_root);
                        if (jerk_calc_reg)
                        begin
                            sqrt_start_reg <= 1'b1;
                            state_reg      <= ST_JERK_ROOT;
                        end
                        else
                        begin
                            jerk_reg  <= '0;
                            state_reg <= ST_OUTPUT;
                        end
                    end
                end
                ST_JERK_ROOT:
                begin
                    if (sqrt_stat.done)
                    begin
                        div_q_reg   <= sqrt_root;
                        div_rem_reg <= '0;
                        div_cnt_reg <= DCNT_W'(ROOT_W);
                        state_reg   <= ST_DIVIDE;
                    end
                end
                ST_DIVIDE:
                begin
                    div_rem_reg <= div_rem_next;
                    div_q_reg   <= div_q_next;
                    div_cnt_reg <= div_cnt_reg - 1'b1;
                    if (div_cnt_reg == DCNT_W'(1))
                    begin
                        jerk_reg  <= JERK_W'(div_q_next);
                        state_reg <= ST_OUTPUT;
                    end
                end
                ST_OUTPUT:
                begin
                    if (out_free)
                    begin
                        result_reg.sampled        <= sampled_reg;
                        result_reg.sample_failed  <= failed_reg;
                        result_reg.magnitude      <= magnitude_reg;
                        result_reg.jerk           <= jerk_reg;
                        result_reg.over_threshold <= item_en_reg && (jerk_reg > threshold_reg);
                        result_valid_reg          <= 1'b1;
                        state_reg                 <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign result_valid = result_valid_reg;
    assign result_data  = result_reg;

    `AJTD_ASSERT_IMPLY(a_flags_exclusive, clk, rst_n,
        result_valid, !(result_data.sampled && result_data.sample_failed),
        "result flags both sampled and failed")
    `AJTD_ASSERT_IMPLY(a_over_means_above, clk, rst_n,
        result_valid && result_data.over_threshold, result_data.jerk > threshold_reg,
        "over flag set without jerk above threshold")
    `AJTD_ASSERT_NEXT(a_tick_advances, clk, rst_n,
        tick_accept && enable_reg, tick_count_reg == $past(tick_count_reg) + 1'b1,
        "tick counter did not advance on an enabled item")
    `AJTD_ASSERT_IMPLY(a_sqrt_start_idle, clk, rst_n,
        sqrt_start_reg, !sqrt_stat.busy,
        "square root started while busy")

endmodule

@@ design/ajtd_isqrt.sv @@
// Iterative integer square root, two radicand bits per cycle.
module ajtd_isqrt
    import ajtd_pkg::*;
#(
    parameter int RAD_W = 50
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [RAD_W-1:0]     radicand,
    output logic [RAD_W/2-1:0]   root,
    output ajtd_sqrt_stat_t      status
);

    localparam int ROOT_W = RAD_W / 2;
    localparam int CNT_W  = $clog2(ROOT_W + 1);

    logic [RAD_W-1:0]  rad_reg;
    logic [ROOT_W+1:0] rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [ROOT_W+1:0] rem_shift;
    logic [ROOT_W+1:0] trial;
    logic              fits;

    assign rem_shift = {rem_reg[ROOT_W-1:0], rad_reg[RAD_W-1:RAD_W-2]};
    assign trial     = {root_reg, 2'b01};
    assign fits      = (rem_shift >= trial);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            rad_reg  <= '0;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                rad_reg  <= radicand;
                rem_reg  <= '0;
                root_reg <= '0;
                cnt_reg  <= CNT_W'(ROOT_W);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                rad_reg <= {rad_reg[RAD_W-3:0], 2'b00};
                if (fits)
                begin
                    rem_reg  <= rem_shift - trial;
                    root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= rem_shift;
                    root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign root        = root_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule
